/* rtl/scgr_pkg.sv */
// Shared types, constants and the 5x7 font table of the scaled glyph cell rasterizer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package scgr_pkg;

    localparam int MAX_SCALE_DEF  = 15;
    localparam int SCREEN_MAX_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;
    localparam int FONT_ROWS      = 7;
    localparam int FONT_COLS      = 5;
    localparam int FONT_GLYPHS    = 36;

    // Glyph codes after classification: 0..35 index the font table.
    localparam logic [5:0] GLYPH_DIGIT0 = 6'd26;
    localparam logic [5:0] GLYPH_DASH   = 6'd36;
    localparam logic [5:0] GLYPH_DOT    = 6'd37;
    localparam logic [5:0] GLYPH_COLON  = 6'd38;
    localparam logic [5:0] GLYPH_SLASH  = 6'd39;
    localparam logic [5:0] GLYPH_BLANK  = 6'd40;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_RED_SHIFT     = 3'd2,
        REG_RED_BITS      = 3'd3,
        REG_GREEN_SHIFT   = 3'd4,
        REG_GREEN_BITS    = 3'd5,
        REG_BLUE_SHIFT    = 3'd6,
        REG_BLUE_BITS     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [5:0]  glyph;
        logic [31:0] pixel;
        logic [3:0]  scale;
    } t_cmd;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
    } t_screen;

    localparam logic [4:0] FONT_ROM [FONT_GLYPHS][FONT_ROWS] = '{
        '{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}, '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
        '{5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E}, '{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
        '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F}, '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
        '{5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F}, '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
        '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F}, '{5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
        '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11}, '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
        '{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11}, '{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
        '{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
        '{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D}, '{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
        '{5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E}, '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
        '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
        '{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A}, '{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
        '{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
        '{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}, '{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
        '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F}, '{5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E},
        '{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}, '{5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E},
        '{5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
        '{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}, '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E}
    };

    // Dot pattern of one glyph row; bit 4 is the leftmost column.
    function automatic logic [4:0] dot_row(logic [5:0] glyph, logic [2:0] row);
        logic [4:0] bits;
        bits = 5'h00;
        unique case (glyph)
            GLYPH_DASH:  bits = (row == 3'd3) ? 5'h1F : 5'h00;
            GLYPH_DOT:   bits = (row == 3'd6) ? 5'h04 : 5'h00;
            GLYPH_COLON: bits = (row == 3'd2 || row == 3'd5) ? 5'h04 : 5'h00;
            GLYPH_SLASH: bits = (row > 3'd4) ? 5'h01 : (5'h10 >> row);
            default: begin
                if (glyph < 6'(FONT_GLYPHS)) begin
                    bits = FONT_ROM[glyph][row];
                end
            end
        endcase
        return bits;
    endfunction

endpackage

/* rtl/scgr_if.sv */
// Handshake channels of the scaled glyph cell rasterizer: command, configuration, result.
// Each carries valid, ready and its payload; no package dependency.
`timescale 1ns / 1ps

interface scgr_cmd_if;
    logic        valid;
    logic        ready;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [7:0]  char_code;
    logic [23:0] rgb_color;
    logic [3:0]  scale_factor;

    modport source (output valid, origin_x, origin_y, char_code, rgb_color, scale_factor,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, char_code, rgb_color, scale_factor,
                    output ready);
endinterface

interface scgr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface scgr_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] cell_x;
    logic [11:0] cell_y;
    logic [3:0]  cell_width;
    logic [3:0]  cell_height;
    logic [31:0] pixel_value;
    logic        last_cell;

    modport source (output valid, cell_x, cell_y, cell_width, cell_height, pixel_value,
                    last_cell, input ready);
    modport sink   (input valid, cell_x, cell_y, cell_width, cell_height, pixel_value,
                    last_cell, output ready);
endinterface

/* rtl/scgr_front.sv */
// Front end: configuration registers, command acceptance, glyph classification and
// colour packing. Depends on scgr_pkg and scgr_if.
`timescale 1ns / 1ps

module scgr_front #(
    parameter int MAX_SCALE = scgr_pkg::MAX_SCALE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scgr_cmd_if.sink          i_cmd,
    scgr_cfg_if.sink          i_cfg,
    input  logic              i_queue_full,
    output logic              o_push,
    output scgr_pkg::t_cmd    o_entry,
    output scgr_pkg::t_screen o_screen
);

    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [4:0]  r_red_shift;
    logic [3:0]  r_red_bits;
    logic [4:0]  r_green_shift;
    logic [3:0]  r_green_bits;
    logic [4:0]  r_blue_shift;
    logic [3:0]  r_blue_bits;

    logic [7:0]  w_code;
    logic [5:0]  w_glyph;
    logic [3:0]  w_scale;
    logic [31:0] w_pixel;

    function automatic logic [31:0] pack_chan(logic [7:0] v, logic [3:0] bits,
                                              logic [4:0] sh);
        logic [3:0] b;
        b = (bits > 4'd8) ? 4'd8 : bits;
        return ({24'd0, v} >> (4'd8 - b)) << sh;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = !i_queue_full;
    assign o_push      = i_cmd.valid && !i_queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= 13'd1024;
            r_height      <= 13'd768;
            r_red_shift   <= 5'd16;
            r_red_bits    <= 4'd8;
            r_green_shift <= 5'd8;
            r_green_bits  <= 4'd8;
            r_blue_shift  <= 5'd0;
            r_blue_bits   <= 4'd8;
        end else if (i_cfg.valid) begin
            unique case (scgr_pkg::t_reg_idx'(i_cfg.index))
                scgr_pkg::REG_SCREEN_WIDTH:  r_width       <= i_cfg.data;
                scgr_pkg::REG_SCREEN_HEIGHT: r_height      <= i_cfg.data;
                scgr_pkg::REG_RED_SHIFT:     r_red_shift   <= i_cfg.data[4:0];
                scgr_pkg::REG_RED_BITS:      r_red_bits    <= i_cfg.data[3:0];
                scgr_pkg::REG_GREEN_SHIFT:   r_green_shift <= i_cfg.data[4:0];
                scgr_pkg::REG_GREEN_BITS:    r_green_bits  <= i_cfg.data[3:0];
                scgr_pkg::REG_BLUE_SHIFT:    r_blue_shift  <= i_cfg.data[4:0];
                scgr_pkg::REG_BLUE_BITS:     r_blue_bits   <= i_cfg.data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Lowercase folds onto uppercase; anything unknown becomes a blank glyph.
    always_comb begin
        w_code  = i_cmd.char_code;
        w_glyph = scgr_pkg::GLYPH_BLANK;
        if (w_code >= 8'h61 && w_code <= 8'h7A) begin
            w_glyph = 6'(w_code - 8'h61);
        end else if (w_code >= 8'h41 && w_code <= 8'h5A) begin
            w_glyph = 6'(w_code - 8'h41);
        end else if (w_code >= 8'h30 && w_code <= 8'h39) begin
            w_glyph = scgr_pkg::GLYPH_DIGIT0 + 6'(w_code - 8'h30);
        end else if (w_code == 8'h2D) begin
            w_glyph = scgr_pkg::GLYPH_DASH;
        end else if (w_code == 8'h2E) begin
            w_glyph = scgr_pkg::GLYPH_DOT;
        end else if (w_code == 8'h3A) begin
            w_glyph = scgr_pkg::GLYPH_COLON;
        end else if (w_code == 8'h2F) begin
            w_glyph = scgr_pkg::GLYPH_SLASH;
        end
    end

    // A zero channel width anywhere selects the default 8:8:8 layout.
    always_comb begin
        if (r_red_bits == 4'd0 || r_green_bits == 4'd0 || r_blue_bits == 4'd0) begin
            w_pixel = {8'd0, i_cmd.rgb_color};
        end else begin
            w_pixel = pack_chan(i_cmd.rgb_color[23:16], r_red_bits, r_red_shift)
                    | pack_chan(i_cmd.rgb_color[15:8], r_green_bits, r_green_shift)
                    | pack_chan(i_cmd.rgb_color[7:0], r_blue_bits, r_blue_shift);
        end
    end

    assign w_scale = (int'(i_cmd.scale_factor) > MAX_SCALE) ? 4'(MAX_SCALE)
                                                            : i_cmd.scale_factor;

    assign o_entry.origin_x = i_cmd.origin_x;
    assign o_entry.origin_y = i_cmd.origin_y;
    assign o_entry.glyph    = w_glyph;
    assign o_entry.pixel    = w_pixel;
    assign o_entry.scale    = w_scale;

    assign o_screen.width   = r_width;
    assign o_screen.height  = r_height;

endmodule

/* rtl/scgr_cmd_queue.sv */
// Short command queue between the front end and the cell scanner.
// Depends on scgr_pkg for the entry type and depth.
`timescale 1ns / 1ps

module scgr_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scgr_pkg::t_cmd i_entry,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_head_vld,
    output scgr_pkg::t_cmd o_head
);

    localparam int PTR_W = (scgr_pkg::QUEUE_DEPTH > 1) ? $clog2(scgr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(scgr_pkg::QUEUE_DEPTH + 1);

    scgr_pkg::t_cmd r_mem [scgr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full     = (r_count == CNT_W'(scgr_pkg::QUEUE_DEPTH));
    assign o_head_vld = (r_count != '0);
    assign o_head     = r_mem[r_rptr];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_head_vld;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(scgr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(scgr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/scgr_back.sv */
// Back end: scans the 35 glyph dots of a command, one per cycle unless stalled, clips each
// lit dot to the screen and emits its rectangle. Depends on scgr_pkg and scgr_if.
`timescale 1ns / 1ps

module scgr_back #(
    parameter int SCREEN_MAX = scgr_pkg::SCREEN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scgr_pkg::t_screen i_screen,
    input  logic              i_head_vld,
    input  scgr_pkg::t_cmd    i_head,
    output logic              o_pop,
    scgr_res_if.source        o_res
);

    localparam int SCR_W = $clog2(SCREEN_MAX + 1);
    localparam int CMP_W = (SCR_W > 14) ? SCR_W : 14;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} t_state;

    t_state         r_state;
    scgr_pkg::t_cmd r_cmd;
    logic [2:0]     r_row;
    logic [2:0]     r_col;
    logic [6:0]     r_xoff;
    logic [6:0]     r_yoff;

    // One found rectangle is held back until the next one (or the end) shows
    // whether it is the last of the character.
    logic           r_hold_vld;
    logic [11:0]    r_hold_x;
    logic [11:0]    r_hold_y;
    logic [3:0]     r_hold_w;
    logic [3:0]     r_hold_h;

    logic           r_out_vld;
    logic [11:0]    r_out_x;
    logic [11:0]    r_out_y;
    logic [3:0]     r_out_w;
    logic [3:0]     r_out_h;
    logic [31:0]    r_out_pix;
    logic           r_out_last;

    logic [CMP_W-1:0] w_sw;
    logic [CMP_W-1:0] w_sh;
    logic [CMP_W-1:0] w_cx;
    logic [CMP_W-1:0] w_cy;
    logic [4:0]       w_bits;
    logic             w_lit;
    logic             w_vis;
    logic [3:0]       w_w;
    logic [3:0]       w_h;
    logic             w_out_free;
    logic             w_stall;
    logic             w_last_dot;
    logic             w_load_out;

    assign w_sw = (CMP_W'(i_screen.width) > CMP_W'(SCREEN_MAX)) ? CMP_W'(SCREEN_MAX)
                                                                : CMP_W'(i_screen.width);
    assign w_sh = (CMP_W'(i_screen.height) > CMP_W'(SCREEN_MAX)) ? CMP_W'(SCREEN_MAX)
                                                                 : CMP_W'(i_screen.height);

    assign w_bits = scgr_pkg::dot_row(r_cmd.glyph, r_row);
    assign w_lit  = w_bits[3'd4 - r_col];
    assign w_cx   = CMP_W'(r_cmd.origin_x) + CMP_W'(r_xoff);
    assign w_cy   = CMP_W'(r_cmd.origin_y) + CMP_W'(r_yoff);
    assign w_vis  = w_lit && (r_cmd.scale != 4'd0) && (w_cx < w_sw) && (w_cy < w_sh);
    assign w_w    = ((w_cx + CMP_W'(r_cmd.scale)) > w_sw) ? 4'(w_sw - w_cx) : r_cmd.scale;
    assign w_h    = ((w_cy + CMP_W'(r_cmd.scale)) > w_sh) ? 4'(w_sh - w_cy) : r_cmd.scale;

    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_stall    = w_vis && r_hold_vld && !w_out_free;
    assign w_last_dot = (r_row == 3'(scgr_pkg::FONT_ROWS - 1)) &&
                        (r_col == 3'(scgr_pkg::FONT_COLS - 1));

    // The output register takes a new word when a held rectangle is pushed out by the
    // next visible one, or when the character closes.
    assign w_load_out = ((r_state == S_SCAN) && !w_stall && w_vis && r_hold_vld)
                     || ((r_state == S_FINISH) && w_out_free);

    assign o_pop = (r_state == S_IDLE) && i_head_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head_vld) begin
                        r_cmd   <= i_head;
                        r_row   <= 3'd0;
                        r_col   <= 3'd0;
                        r_xoff  <= 7'd0;
                        r_yoff  <= 7'd0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!w_stall) begin
                        if (w_vis) begin
                            if (r_hold_vld) begin
                                r_out_x    <= r_hold_x;
                                r_out_y    <= r_hold_y;
                                r_out_w    <= r_hold_w;
                                r_out_h    <= r_hold_h;
                                r_out_pix  <= r_cmd.pixel;
                                r_out_last <= 1'b0;
                            end
                            r_hold_vld <= 1'b1;
                            r_hold_x   <= w_cx[11:0];
                            r_hold_y   <= w_cy[11:0];
                            r_hold_w   <= w_w;
                            r_hold_h   <= w_h;
                        end
                        if (r_col == 3'(scgr_pkg::FONT_COLS - 1)) begin
                            r_col  <= 3'd0;
                            r_xoff <= 7'd0;
                            r_row  <= r_row + 3'd1;
                            r_yoff <= r_yoff + 7'(r_cmd.scale);
                        end else begin
                            r_col  <= r_col + 3'd1;
                            r_xoff <= r_xoff + 7'(r_cmd.scale);
                        end
                        if (w_last_dot) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_x    <= r_hold_vld ? r_hold_x : 12'd0;
                        r_out_y    <= r_hold_vld ? r_hold_y : 12'd0;
                        r_out_w    <= r_hold_vld ? r_hold_w : 4'd0;
                        r_out_h    <= r_hold_vld ? r_hold_h : 4'd0;
                        r_out_pix  <= r_cmd.pixel;
                        r_out_last <= 1'b1;
                        r_hold_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.cell_x      = r_out_x;
    assign o_res.cell_y      = r_out_y;
    assign o_res.cell_width  = r_out_w;
    assign o_res.cell_height = r_out_h;
    assign o_res.pixel_value = r_out_pix;
    assign o_res.last_cell   = r_out_last;

endmodule

/* rtl/scaled_glyph_cell_rasterizer_top.sv */
// Top level of the scaled glyph cell rasterizer: front end, command queue and cell scanner.
// Depends on scgr_pkg, scgr_if, scgr_front, scgr_cmd_queue and scgr_back.
//
// Usage:
//   i_cmd takes one character draw word (origin, character byte, RGB colour, scale).
//   o_res gives one word per visible lit font dot, a rectangle clipped to the screen
//   with the packed pixel value; last_cell marks the final word of a character.
//   A character with no visible dot gives one word of zero size with last_cell set.
//   i_cfg writes the screen size and colour layout registers; ready is always high,
//   and writes are meant to happen only while no character is in flight.
// Flow:
//   The scanner loads a command, visits all 35 dots of its glyph, one per cycle while
//   the receiver keeps up, and then closes the character. Each rectangle is registered
//   in the hold register and then in the output register; the last word of a character
//   is loaded into the output register when the character closes.
//   A two-word command queue lets the next characters be accepted while one is scanned.
// Reset and stalls:
//   Reset restores 1024x768 and an 8:8:8 layout at bits 16, 8, 0 and empties the
//   queue. When the receiver holds ready low the output register keeps its word, the
//   scanner halts at the next visible dot and the queue fills before i_cmd ready drops.
`timescale 1ns / 1ps

module scaled_glyph_cell_rasterizer_top #(
    parameter int MAX_SCALE  = scgr_pkg::MAX_SCALE_DEF,
    parameter int SCREEN_MAX = scgr_pkg::SCREEN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scgr_cmd_if.sink   i_cmd,
    scgr_cfg_if.sink   i_cfg,
    scgr_res_if.source o_res
);

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_head_vld;
    scgr_pkg::t_cmd    w_entry;
    scgr_pkg::t_cmd    w_head;
    scgr_pkg::t_screen w_screen;

    scgr_front #(
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_cfg        (i_cfg),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_entry      (w_entry),
        .o_screen     (w_screen)
    );

    scgr_cmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_entry    (w_entry),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_head_vld (w_head_vld),
        .o_head     (w_head)
    );

    scgr_back #(
        .SCREEN_MAX (SCREEN_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_screen   (w_screen),
        .i_head_vld (w_head_vld),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule
